[design/hpp_pkg.sv]
`timescale 1ns / 1ps
package hpp_pkg;

    localparam int CoefW = 32;
    localparam int CoordW = 16;
    localparam int ProdW = 48;
    localparam int SumW = 49;
    localparam int CfgW = 64;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_H00_H01 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_H02_H10 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_H11_H12 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_H20_H21 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_H22     = 3'd4;

    typedef struct packed {
        logic signed [CoordW-1:0] row_in;
        logic signed [CoordW-1:0] col_in;
    } t_pt_in;

    typedef struct packed {
        logic signed [CoordW-1:0] row_out;
        logic signed [CoordW-1:0] col_out;
        logic                     degenerate;
        logic                     saturated;
    } t_pt_out;

endpackage

[design/hpp_dot.sv]
`timescale 1ns / 1ps
module hpp_dot (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [hpp_pkg::CoefW-1:0]    i_h_r,
    input  logic signed [hpp_pkg::CoefW-1:0]    i_h_c,
    input  logic signed [hpp_pkg::CoefW-1:0]    i_h_k,
    input  logic signed [hpp_pkg::CoordW-1:0]   i_r,
    input  logic signed [hpp_pkg::CoordW-1:0]   i_c,
    output logic signed [hpp_pkg::SumW-1:0]     o_sum
);
    import hpp_pkg::*;

    logic signed [ProdW-1:0] r_p_r;
    logic signed [ProdW-1:0] r_p_c;
    logic signed [CoefW+3:0] r_k;
    logic signed [SumW-1:0]  r_sum;

    // products, then the three-term sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_r <= i_h_r * i_r;
            r_p_c <= i_h_c * i_c;
            r_k   <= {i_h_k, 4'b0000};
            r_sum <= SumW'(r_p_r) + SumW'(r_p_c) + SumW'(r_k);
        end
    end

    assign o_sum = r_sum;

endmodule

[design/hpp_div.sv]
`timescale 1ns / 1ps
module hpp_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [hpp_pkg::SumW-1:0]     i_num,
    input  logic signed [hpp_pkg::SumW-1:0]     i_den,
    output logic signed [hpp_pkg::CoordW-1:0]   o_q,
    output logic                                o_sat
);
    import hpp_pkg::*;

    localparam int QW = CoordW;
    localparam int MagW = SumW - 1;
    localparam int DW = MagW + 1;
    localparam int NW = MagW + 6;
    localparam int WW = DW + QW + 1;

    logic [MagW-1:0] w_n;
    logic [MagW-1:0] w_d;

    logic [NW-1:0] r_n2;
    logic [DW-1:0] r_d2;
    logic          r_neg;

    logic [NW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_dd  [QW+1];
    logic [QW-1:0] r_qb  [QW+1];
    logic          r_ng  [QW+1];
    logic          r_ovf [QW+1];

    logic [QW-1:0] r_q;
    logic          r_sat;

    assign w_n = i_num[SumW-1] ? MagW'(-i_num) : MagW'(i_num);
    assign w_d = i_den[SumW-1] ? MagW'(-i_den) : MagW'(i_den);

    // 32*n + d over 2*d gives the rounded quotient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n2  <= {w_n, 5'b00000} + NW'(w_d);
            r_d2  <= {w_d, 1'b0};
            r_neg <= i_num[SumW-1] ^ i_den[SumW-1];

            r_rem[0] <= r_n2;
            r_dd[0]  <= r_d2;
            r_qb[0]  <= '0;
            r_ng[0]  <= r_neg;
            r_ovf[0] <= {(WW-NW)'(0), r_n2} >= {1'b0, r_d2, QW'(0)};
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_bit
        logic [WW-1:0] w_sub;
        logic          w_ge;
        logic [QW-1:0] n_q;

        assign w_sub = {(WW-NW)'(0), r_rem[j]} - ({(WW-DW)'(0), r_dd[j]} << (QW-1-j));
        assign w_ge = !w_sub[WW-1];

        always_comb begin
            n_q = r_qb[j];
            n_q[QW-1-j] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? w_sub[NW-1:0] : r_rem[j];
                r_dd[j+1]  <= r_dd[j];
                r_qb[j+1]  <= n_q;
                r_ng[j+1]  <= r_ng[j];
                r_ovf[j+1] <= r_ovf[j];
            end
        end
    end

    // sign and clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_ng[QW]) begin
                r_sat <= r_ovf[QW] || r_qb[QW][QW-1];
                r_q   <= (r_ovf[QW] || r_qb[QW][QW-1]) ? {1'b0, {(QW-1){1'b1}}} : r_qb[QW];
            end else begin
                r_sat <= r_ovf[QW] || (r_qb[QW] > {1'b1, (QW-1)'(0)});
                r_q   <= (r_ovf[QW] || (r_qb[QW] > {1'b1, (QW-1)'(0)}))
                         ? {1'b1, (QW-1)'(0)} : -r_qb[QW];
            end
        end
    end

    assign o_q = r_q;
    assign o_sat = r_sat;

endmodule

[design/homography_point_projection.sv]
`timescale 1ns / 1ps
// Maps a Q12.4 point (row, col) through a 3x3 homography with Q12.20
// coefficients and returns (a/k, b/k) rounded to Q12.4, ties away from zero,
// clamped to the 16-bit range with a saturation flag; k equal to zero gives
// (0,0) and the degenerate flag. One request enters per clock while the output
// is not stalled and passes the product and sum registers, then a divider
// that retires one quotient bit per stage. Stall on the output freezes the
// whole pipeline. Coefficients may be written only while the pipeline is empty.
module homography_point_projection (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  hpp_pkg::t_pt_in                 i_req,
    output logic                            o_valid,
    input  logic                            i_stall,
    output hpp_pkg::t_pt_out                o_res,
    input  logic                            i_cfg_we,
    input  logic [hpp_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [hpp_pkg::CfgW-1:0]        i_cfg_data
);
    import hpp_pkg::*;

    localparam int Depth = 21;
    localparam int DivLat = 19;

    logic [CfgW-1:0]  r_c0, r_c1, r_c2, r_c3;
    logic [CoefW-1:0] r_c4;

    logic [Depth-1:0]  r_vld;
    logic [DivLat-1:0] r_deg;
    logic              w_en;

    logic signed [SumW-1:0]   w_a, w_b, w_k;
    logic signed [CoordW-1:0] w_row, w_col;
    logic                     w_sat_r, w_sat_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= {32'h0010_0000, 32'h0};
            r_c1 <= '0;
            r_c2 <= {32'h0010_0000, 32'h0};
            r_c3 <= '0;
            r_c4 <= 32'h0010_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_H00_H01: r_c0 <= i_cfg_data;
                REG_H02_H10: r_c1 <= i_cfg_data;
                REG_H11_H12: r_c2 <= i_cfg_data;
                REG_H20_H21: r_c3 <= i_cfg_data;
                REG_H22:     r_c4 <= i_cfg_data[CoefW-1:0];
                default: ;
            endcase
        end
    end

    assign w_en = !(r_vld[Depth-1] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg <= {r_deg[DivLat-2:0], w_k == '0};
        end
    end

    hpp_dot u_dot_a (
        .i_clk (i_clk), .i_en (w_en),
        .i_h_r (r_c0[63:32]), .i_h_c (r_c0[31:0]), .i_h_k (r_c1[63:32]),
        .i_r (i_req.row_in), .i_c (i_req.col_in), .o_sum (w_a)
    );

    hpp_dot u_dot_b (
        .i_clk (i_clk), .i_en (w_en),
        .i_h_r (r_c1[31:0]), .i_h_c (r_c2[63:32]), .i_h_k (r_c2[31:0]),
        .i_r (i_req.row_in), .i_c (i_req.col_in), .o_sum (w_b)
    );

    hpp_dot u_dot_k (
        .i_clk (i_clk), .i_en (w_en),
        .i_h_r (r_c3[63:32]), .i_h_c (r_c3[31:0]), .i_h_k (r_c4),
        .i_r (i_req.row_in), .i_c (i_req.col_in), .o_sum (w_k)
    );

    hpp_div u_div_row (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_a), .i_den (w_k),
        .o_q (w_row), .o_sat (w_sat_r)
    );

    hpp_div u_div_col (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_b), .i_den (w_k),
        .o_q (w_col), .o_sat (w_sat_c)
    );

    assign o_valid = r_vld[Depth-1];
    assign o_res.row_out = r_deg[DivLat-1] ? '0 : w_row;
    assign o_res.col_out = r_deg[DivLat-1] ? '0 : w_col;
    assign o_res.degenerate = r_deg[DivLat-1];
    assign o_res.saturated = !r_deg[DivLat-1] && (w_sat_r || w_sat_c);

endmodule
